// File: design/med_pkg.sv
// ============================================================================
// med_pkg : shared types and constants of the envelope detector
// Field widths, configuration register indexes and the root unit result type.
// ============================================================================
package med_pkg;

    localparam int CH_W     = 3;   // channel field
    localparam int SAMPLE_W = 16;  // Q1.15 sample
    localparam int COEF_W   = 16;  // Q0.16 coefficient
    localparam int LEVEL_W  = 31;  // stored detector value
    localparam int ENV_W    = 16;  // envelope result
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE   = 2'd2;

    localparam logic MODE_PEAK = 1'b0;
    localparam logic MODE_RMS  = 1'b1;

    typedef struct packed {
        logic             done;
        logic [ENV_W-1:0] root;
    } sqrt_result_t;

endpackage

// File: design/med_ram.sv
// ============================================================================
// med_ram : generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module med_ram #(
    parameter  int WIDTH  = 31,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/med_sqrt.sv
// ============================================================================
// med_sqrt : iterative floor square root
// Restoring digit-by-digit root of a 31-bit value, one root bit per cycle.
// ============================================================================
module med_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [med_pkg::LEVEL_W-1:0]   radicand,
    output med_pkg::sqrt_result_t         result
);
    import med_pkg::*;

    localparam int X_W   = 2 * ENV_W;
    localparam int REM_W = ENV_W + 4;
    localparam int CNT_W = $clog2(ENV_W);

    logic [X_W-1:0]   x_reg,    x_next;
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [ENV_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[X_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = X_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ENV_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[X_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ENV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ENV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign result.done = done_reg;
    assign result.root = root_reg;

endmodule

// File: design/multichannel_envelope_detector.sv
// ============================================================================
// multichannel_envelope_detector : attack/release envelope follower, peak or RMS
// Each request carries a channel number and a signed Q1.15 sample and returns
// one envelope value. The per-channel detector values live in a small RAM
// that is read, updated and written back once per request; one request is in
// flight at a time. The RAM read happens at the accepting edge. A request
// passes through difference, multiply, write-back and output from acceptance
// to a loaded result in peak mode; in RMS mode the 16-step iterative square
// root unit runs between write-back and output. An out-of-range channel goes
// straight to output and returns zero. A new request is taken the cycle after
// the result is loaded, even while that result still waits downstream, so
// no new request is taken before the last one's result is loaded. Writing
// level_mode clears every channel at once through per-channel valid flags;
// no clearing pass is needed.
// Configure only while the block is idle.
// ============================================================================
module multichannel_envelope_detector #(
    parameter int CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [med_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [med_pkg::COEF_W-1:0]      cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [med_pkg::CH_W-1:0]        channel,
    input  logic signed [med_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [med_pkg::ENV_W-1:0]       envelope
);
    import med_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIFF_W = LEVEL_W + 2;
    localparam int PROD_W = DIFF_W + COEF_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // configuration registers
    logic [COEF_W-1:0]   attack_reg,  attack_next;
    logic [COEF_W-1:0]   release_reg, release_next;
    logic                mode_reg,    mode_next;
    logic [CHANNELS-1:0] valid_reg,   valid_next;

    // control
    logic [2:0]          state_reg,   state_next;
    logic                out_valid_reg, out_valid_next;

    // datapath
    logic [ADDR_W-1:0]        addr_reg,     addr_next;
    logic [LEVEL_W-1:0]       level_reg,    level_next;
    logic signed [DIFF_W-1:0] diff_reg,     diff_next;
    logic [COEF_W-1:0]        coef_reg,     coef_next;
    logic signed [PROD_W-1:0] prod_reg,     prod_next;
    logic [ENV_W-1:0]         env_reg,      env_next;
    logic [ENV_W-1:0]         envelope_reg, envelope_next;

    logic                     in_accept;
    logic                     ch_ok;
    logic [SAMPLE_W-1:0]      mag;
    logic signed [2*SAMPLE_W-1:0] square;
    logic [LEVEL_W-1:0]       y_cur;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] ny_full;
    logic [LEVEL_W-1:0]       ny;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [LEVEL_W-1:0]  ram_rdata;

    logic                sqrt_start;
    sqrt_result_t        sqrt_res;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign ch_ok     = (32'(channel) < CHANNELS);

    // detected level: magnitude or square
    assign mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
    assign square = sample * sample;

    // an entry not written since the last clear reads as zero
    assign y_cur = valid_reg[addr_reg] ? ram_rdata : '0;

    // floor shift: arithmetic shift rounds toward minus infinity
    assign adj     = prod_reg >>> COEF_W;
    assign ny_full = $signed({{(PROD_W-LEVEL_W){1'b0}}, level_reg}) + adj;
    assign ny      = ny_full[LEVEL_W-1:0];

    assign ram_raddr  = (state_reg == S_IDLE) ? ADDR_W'(channel) : addr_reg;
    assign ram_we     = (state_reg == S_WB);
    assign sqrt_start = (state_reg == S_WB) && (mode_reg == MODE_RMS);

    med_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (CHANNELS)
    ) u_level_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ny),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    med_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (ny),
        .result   (sqrt_res)
    );

    always_comb
    begin
        attack_next    = attack_reg;
        release_next   = release_reg;
        mode_next      = mode_reg;
        valid_next     = valid_reg;
        state_next     = state_reg;
        addr_next      = addr_reg;
        level_next     = level_reg;
        diff_next      = diff_reg;
        coef_next      = coef_reg;
        prod_next      = prod_reg;
        env_next       = env_reg;
        envelope_next  = envelope_reg;
        // drop the result once downstream takes it
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_ATTACK_COEF:  attack_next  = cfg_data;
                REG_RELEASE_COEF: release_next = cfg_data;
                REG_LEVEL_MODE:
                begin
                    mode_next  = cfg_data[0];
                    valid_next = '0;
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    addr_next  = ADDR_W'(channel);
                    level_next = (mode_reg == MODE_RMS) ? LEVEL_W'(square)
                                                        : LEVEL_W'(mag);
                    if (ch_ok)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        env_next   = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_READ:
            begin
                // y - d, and pick attack when the level rises
                diff_next  = $signed({2'b00, y_cur}) - $signed({2'b00, level_reg});
                coef_next  = (level_reg > y_cur) ? attack_reg : release_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = $signed({{(PROD_W-COEF_W){1'b0}}, coef_reg})
                           * $signed({{(PROD_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg});
                state_next = S_ROOT;
                if (mode_reg == MODE_PEAK)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // write back and mark the entry live
                valid_next[addr_reg] = 1'b1;
                if (mode_reg == MODE_RMS)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    env_next   = ny[ENV_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_ROOT:
            begin
                if (sqrt_res.done)
                begin
                    env_next   = sqrt_res.root;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    envelope_next  = env_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= '0;
            release_reg   <= '0;
            mode_reg      <= MODE_PEAK;
            valid_reg     <= '0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            attack_reg    <= attack_next;
            release_reg   <= release_next;
            mode_reg      <= mode_next;
            valid_reg     <= valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        level_reg    <= level_next;
        diff_reg     <= diff_next;
        coef_reg     <= coef_next;
        prod_reg     <= prod_next;
        env_reg      <= env_next;
        envelope_reg <= envelope_next;
    end

    assign out_valid = out_valid_reg;
    assign envelope  = envelope_reg;

endmodule
